// File: hdl/u128alu_pkg.sv
`default_nettype none

package u128alu_pkg;

  localparam int unsigned WIDE_W = 128;
  localparam int unsigned HALF_W = 64;
  localparam int unsigned STEP_W = 7;
  localparam int unsigned AMT_W  = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_NOT = 4'd7,
    OP_NEG = 4'd8,
    OP_SHL = 4'd9,
    OP_SHR = 4'd10,
    OP_EQ  = 4'd11,
    OP_LT  = 4'd12
  } op_t;

  typedef struct packed {
    logic [WIDE_W-1:0] x;
    logic [WIDE_W-1:0] y;
    logic              sub;
  } addsub_in_t;

endpackage

`default_nettype wire

// File: hdl/u128alu_addsub.sv
`default_nettype none

module u128alu_addsub (
  input  wire u128alu_pkg::addsub_in_t       opnd,
  output logic [u128alu_pkg::WIDE_W-1:0]     sum,
  output logic                               carry
);

  logic [u128alu_pkg::WIDE_W-1:0] y_eff;

  assign y_eff = opnd.sub ? ~opnd.y : opnd.y;
  assign {carry, sum} = {1'b0, opnd.x} + {1'b0, y_eff}
                      + {{u128alu_pkg::WIDE_W{1'b0}}, opnd.sub};

endmodule

`default_nettype wire

// File: hdl/uint128_arith_logic_unit.sv
// Sequencing: add, sub, logic, shift and compare requests pass through the exec and write
//   states; mul, div and mod also take 128 steps of the shared 128-bit adder in between,
//   except that div and mod with a zero divisor go straight from exec to write.
// Issue: one request at a time; the next request is taken once the current response
//   is loaded into the output register, which waits while a held response is stalled.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops rsp_valid.
`default_nettype none

module uint128_arith_logic_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [3:0]  req_type,
  input  wire logic [63:0] a_lo,
  input  wire logic [63:0] a_hi,
  input  wire logic [63:0] b_lo,
  input  wire logic [63:0] b_hi,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [63:0]      result_lo,
  output logic [63:0]      result_hi,
  output logic             compare_true,
  output logic             div_by_zero
);

  localparam int unsigned W  = u128alu_pkg::WIDE_W;
  localparam int unsigned H  = u128alu_pkg::HALF_W;
  localparam int unsigned SW = u128alu_pkg::STEP_W;
  localparam int unsigned AW = u128alu_pkg::AMT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t             state;
  u128alu_pkg::op_t   op;
  logic [W-1:0]       a;
  logic [W-1:0]       b;
  logic [W-1:0]       acc;
  logic [W-1:0]       q;
  logic [SW-1:0]      step;
  logic               cmp;
  logic               dz;

  u128alu_pkg::addsub_in_t opnd;
  logic [W-1:0]       sum;
  logic               carry;
  logic [W-1:0]       shl_res;
  logic [W-1:0]       shr_res;
  logic [W-1:0]       rem_shift;
  logic               step_last;
  logic               out_free;
  logic [W-1:0]       res_sel;
  logic [W-1:0]       exec_acc;
  logic               exec_cmp;
  logic               exec_dz;
  state_t             exec_state;

  u128alu_addsub u_addsub (
    .opnd  (opnd),
    .sum   (sum),
    .carry (carry)
  );

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign step_last = (step == {SW{1'b1}});
  assign rem_shift = {acc[W-2:0], a[W-1]};
  assign shl_res   = (|b[AW-1:SW]) ? {W{1'b0}} : (a << b[SW-1:0]);
  assign shr_res   = (|b[AW-1:SW]) ? {W{1'b0}} : (a >> b[SW-1:0]);
  assign res_sel   = (op == u128alu_pkg::OP_DIV) ? q : acc;

  always_comb begin
    opnd.x   = a;
    opnd.y   = b;
    opnd.sub = 1'b0;
    unique case (state)
      S_MUL: begin
        opnd.x = acc;
        opnd.y = a;
      end
      S_DIV: begin
        opnd.x   = rem_shift;
        opnd.sub = 1'b1;
      end
      default: begin
        unique case (op) inside
          u128alu_pkg::OP_SUB, u128alu_pkg::OP_LT: opnd.sub = 1'b1;
          u128alu_pkg::OP_NEG: begin
            opnd.x   = {W{1'b0}};
            opnd.y   = a;
            opnd.sub = 1'b1;
          end
          default: opnd.sub = 1'b0;
        endcase
      end
    endcase
  end

  always_comb begin
    exec_acc   = {W{1'b0}};
    exec_cmp   = 1'b0;
    exec_dz    = 1'b0;
    exec_state = S_WRITE;
    unique case (op) inside
      u128alu_pkg::OP_ADD, u128alu_pkg::OP_SUB, u128alu_pkg::OP_NEG: exec_acc = sum;
      u128alu_pkg::OP_MUL: exec_state = S_MUL;
      u128alu_pkg::OP_DIV, u128alu_pkg::OP_MOD: begin
        if (b == {W{1'b0}}) begin
          exec_dz = 1'b1;
        end else begin
          exec_state = S_DIV;
        end
      end
      u128alu_pkg::OP_AND: exec_acc = a & b;
      u128alu_pkg::OP_OR:  exec_acc = a | b;
      u128alu_pkg::OP_NOT: exec_acc = ~a;
      u128alu_pkg::OP_SHL: exec_acc = shl_res;
      u128alu_pkg::OP_SHR: exec_acc = shr_res;
      u128alu_pkg::OP_EQ:  exec_cmp = (a == b);
      u128alu_pkg::OP_LT:  exec_cmp = !carry;
      default: exec_acc = {W{1'b0}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_WRITE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= u128alu_pkg::op_t'(req_type);
            a     <= {a_hi, a_lo};
            b     <= {b_hi, b_lo};
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          cmp   <= exec_cmp;
          dz    <= exec_dz;
          acc   <= exec_acc;
          q     <= {W{1'b0}};
          step  <= {SW{1'b0}};
          state <= exec_state;
        end
        S_MUL: begin
          if (b[0]) begin
            acc <= sum;
          end
          a    <= {a[W-2:0], 1'b0};
          b    <= {1'b0, b[W-1:1]};
          step <= step + 1'b1;
          if (step_last) begin
            state <= S_WRITE;
          end
        end
        S_DIV: begin
          if (acc[W-1] || carry) begin
            acc <= sum;
            q   <= {q[W-2:0], 1'b1};
          end else begin
            acc <= rem_shift;
            q   <= {q[W-2:0], 1'b0};
          end
          a    <= {a[W-2:0], 1'b0};
          step <= step + 1'b1;
          if (step_last) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            result_lo    <= res_sel[H-1:0];
            result_hi    <= res_sel[W-1:H];
            compare_true <= cmp;
            div_by_zero  <= dz;
            rsp_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: verif/uint128_arith_logic_unit_checker.sv
`timescale 1ns / 100ps

module uint128_arith_logic_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [3:0]  req_type,
  input  logic [63:0] a_lo,
  input  logic [63:0] a_hi,
  input  logic [63:0] b_lo,
  input  logic [63:0] b_hi,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [63:0] result_lo,
  input  logic [63:0] result_hi,
  input  logic        compare_true,
  input  logic        div_by_zero,
  output int          fail_count,
  output int          outstanding
);

  localparam int unsigned DEPTH = 8;

  typedef struct packed {
    logic [u128alu_pkg::WIDE_W-1:0] value;
    logic                           holds;
    logic                           zero_div;
  } alu_answer_t;

  alu_answer_t answer_fifo [DEPTH];
  logic [2:0]  wr_ptr     = '0;
  logic [2:0]  rd_ptr     = '0;
  int          held       = 0;
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic alu_answer_t compute_answer(
      input logic [3:0] op,
      input logic [u128alu_pkg::WIDE_W-1:0] x,
      input logic [u128alu_pkg::WIDE_W-1:0] y);
    alu_answer_t                   ans;
    logic [u128alu_pkg::AMT_W-1:0] amount;
    amount = y[u128alu_pkg::AMT_W-1:0];
    ans    = '0;
    case (u128alu_pkg::op_t'(op)) inside
      u128alu_pkg::OP_ADD: ans.value = x + y;
      u128alu_pkg::OP_SUB: ans.value = x - y;
      u128alu_pkg::OP_MUL: ans.value = x * y;
      u128alu_pkg::OP_DIV, u128alu_pkg::OP_MOD: begin
        if (y == '0) begin
          ans.zero_div = 1'b1;
        end else begin
          ans.value = (u128alu_pkg::op_t'(op) == u128alu_pkg::OP_DIV) ? x / y : x % y;
        end
      end
      u128alu_pkg::OP_AND: ans.value = x & y;
      u128alu_pkg::OP_OR:  ans.value = x | y;
      u128alu_pkg::OP_NOT: ans.value = ~x;
      u128alu_pkg::OP_NEG: ans.value = -x;
      u128alu_pkg::OP_SHL: ans.value = (amount >= u128alu_pkg::WIDE_W) ? '0 : x << amount;
      u128alu_pkg::OP_SHR: ans.value = (amount >= u128alu_pkg::WIDE_W) ? '0 : x >> amount;
      u128alu_pkg::OP_EQ:  ans.holds = (x == y);
      u128alu_pkg::OP_LT:  ans.holds = (x < y);
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    alu_answer_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        if (held == DEPTH) begin
          $error("request overflow: %0d answers pending", held);
          mismatches++;
        end else begin
          answer_fifo[wr_ptr] = compute_answer(req_type, {a_hi, a_lo}, {b_hi, b_lo});
          wr_ptr = wr_ptr + 3'd1;
          held++;
        end
      end
      if (rsp_valid && !rsp_stall) begin
        if (held == 0) begin
          $error("unexpected response: result %h_%h", result_hi, result_lo);
          mismatches++;
        end else begin
          want   = answer_fifo[rd_ptr];
          rd_ptr = rd_ptr + 3'd1;
          held--;
          if (result_lo !== want.value[u128alu_pkg::HALF_W-1:0]) begin
            $error("result_lo: expected %h, got %h",
                   want.value[u128alu_pkg::HALF_W-1:0], result_lo);
            mismatches++;
          end
          if (result_hi !== want.value[u128alu_pkg::WIDE_W-1:u128alu_pkg::HALF_W]) begin
            $error("result_hi: expected %h, got %h",
                   want.value[u128alu_pkg::WIDE_W-1:u128alu_pkg::HALF_W], result_hi);
            mismatches++;
          end
          if (compare_true !== want.holds) begin
            $error("compare_true: expected %b, got %b", want.holds, compare_true);
            mismatches++;
          end
          if (div_by_zero !== want.zero_div) begin
            $error("div_by_zero: expected %b, got %b", want.zero_div, div_by_zero);
            mismatches++;
          end
        end
      end
    end
    outstanding <= held;
  end

endmodule

// File: verif/uint128_arith_logic_unit_test.sv
`timescale 1ns / 100ps

module uint128_arith_logic_unit_test;

  localparam logic [3:0]   OP_SPARE_LO = 4'd13;
  localparam logic [3:0]   OP_SPARE_HI = 4'd15;
  localparam logic [127:0] ALL_ONES    = '1;
  localparam int           NUM_RANDOM  = 1025;
  localparam int           STALL_LIMIT = 5000;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        req_valid    = 1'b0;
  logic        req_stall;
  logic [3:0]  req_type     = '0;
  logic [63:0] a_lo         = '0;
  logic [63:0] a_hi         = '0;
  logic [63:0] b_lo         = '0;
  logic [63:0] b_hi         = '0;
  logic        rsp_valid;
  logic        rsp_stall    = 1'b0;
  logic [63:0] result_lo;
  logic [63:0] result_hi;
  logic        compare_true;
  logic        div_by_zero;

  logic        quiet        = 1'b0;
  int          fail_count;
  int          outstanding;
  int          idle_cycles  = 0;

  always #4 clk = ~clk;

  uint128_arith_logic_unit dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .a_lo         (a_lo),
    .a_hi         (a_hi),
    .b_lo         (b_lo),
    .b_hi         (b_hi),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_lo    (result_lo),
    .result_hi    (result_hi),
    .compare_true (compare_true),
    .div_by_zero  (div_by_zero)
  );

  uint128_arith_logic_unit_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .a_lo         (a_lo),
    .a_hi         (a_hi),
    .b_lo         (b_lo),
    .b_hi         (b_hi),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_lo    (result_lo),
    .result_hi    (result_hi),
    .compare_true (compare_true),
    .div_by_zero  (div_by_zero),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(99) < 12);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [3:0] op, input logic [127:0] x,
                              input logic [127:0] y);
    while (!quiet && $urandom_range(99) < 12) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= op;
    a_lo      <= x[63:0];
    a_hi      <= x[127:64];
    b_lo      <= y[63:0];
    b_hi      <= y[127:64];
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [127:0] pick_operand();
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = 128'd1 << $urandom_range(127);
      3: v = 128'($urandom_range(255));
      4: v[127:64] = '0;
      5: v[63:0] = '0;
      6: v = v >> $urandom_range(127);
      default: ;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    logic [3:0]   op;
    logic [127:0] x;
    logic [127:0] y;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_request(u128alu_pkg::OP_ADD, ALL_ONES, 128'd1);
    send_request(u128alu_pkg::OP_SUB, '0, 128'd1);
    send_request(u128alu_pkg::OP_MUL, ALL_ONES, ALL_ONES);
    send_request(u128alu_pkg::OP_MUL, 128'hfedcba98_76543210_01234567_89abcdef, 128'h1_00000001);
    send_request(u128alu_pkg::OP_DIV, 128'h1234_5678, '0);
    send_request(u128alu_pkg::OP_MOD, ALL_ONES, '0);
    send_request(u128alu_pkg::OP_DIV, ALL_ONES, 128'd1);
    send_request(u128alu_pkg::OP_DIV, 128'd5, ALL_ONES);
    send_request(u128alu_pkg::OP_MOD, ALL_ONES, 128'h1_00000000_00000003);
    send_request(u128alu_pkg::OP_AND, ALL_ONES, 128'ha5a5a5a5_0f0f0f0f_3c3c3c3c_96969696);
    send_request(u128alu_pkg::OP_OR, '0, 128'h5a5a5a5a_f0f0f0f0_c3c3c3c3_69696969);
    send_request(u128alu_pkg::OP_NOT, '0, ALL_ONES);
    send_request(u128alu_pkg::OP_NEG, '0, ALL_ONES);
    send_request(u128alu_pkg::OP_NEG, 128'd1, ALL_ONES);
    send_request(u128alu_pkg::OP_SHL, ALL_ONES, '0);
    send_request(u128alu_pkg::OP_SHL, 128'd1, 128'd127);
    send_request(u128alu_pkg::OP_SHL, ALL_ONES, 128'd128);
    send_request(u128alu_pkg::OP_SHL, ALL_ONES, {64'hffffffff_ffffffff, 64'hdeadbeef_00000041});
    send_request(u128alu_pkg::OP_SHR, ALL_ONES, 128'd64);
    send_request(u128alu_pkg::OP_SHR, ALL_ONES, 128'hffff_ffff);
    send_request(u128alu_pkg::OP_EQ, ALL_ONES, ALL_ONES);
    send_request(u128alu_pkg::OP_EQ, ALL_ONES, ALL_ONES - 128'd1);
    send_request(u128alu_pkg::OP_LT, {64'd7, 64'd3}, {64'd7, 64'd4});
    send_request(u128alu_pkg::OP_LT, ALL_ONES, ALL_ONES);
    send_request(OP_SPARE_LO, ALL_ONES, ALL_ONES);
    send_request(OP_SPARE_HI, ALL_ONES, ALL_ONES);
    wait_drained();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet = (i >= 400 && i < 600);
      if (i > 0 && i % 250 == 0) wait_drained();
      if ($urandom_range(19) == 0) begin
        op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      end else begin
        op = 4'($urandom_range(u128alu_pkg::OP_LT, u128alu_pkg::OP_ADD));
      end
      x = pick_operand();
      y = pick_operand();
      case (op) inside
        u128alu_pkg::OP_SHL, u128alu_pkg::OP_SHR:
          if ($urandom_range(3) != 0) y[31:0] = $urandom_range(140);
        u128alu_pkg::OP_EQ: if ($urandom_range(1) != 0) y = x;
        u128alu_pkg::OP_LT: if ($urandom_range(1) != 0) y[127:64] = x[127:64];
        u128alu_pkg::OP_DIV, u128alu_pkg::OP_MOD:
          if ($urandom_range(3) == 0) y = y >> $urandom_range(127);
        default: ;
      endcase
      send_request(op, x, y);
    end
    quiet = 1'b0;

    wait_drained();
    repeat (150) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
